// ----- hw/rtl/b3ptc_pkg.sv -----
// Shared types, constants and helper functions for the base-3 product top-carry block.
package b3ptc_pkg;

  // Field widths
  localparam int OPND_W  = 20;
  localparam int FIELD_W = 5;
  localparam int TOTAL_W = 48;

  // An operand below 2^20 splits into five base-27 chunks of three base-3 digits each
  localparam int CHUNKS        = 5;
  localparam int DIG_PER_CHUNK = 3;
  localparam int CHUNK_W       = 5;
  localparam int ALL_DIGITS    = CHUNKS * DIG_PER_CHUNK;

  // Carry positions resolved by one carry stage
  localparam int STEPS_PER_STAGE = 4;

  // Reciprocals for floor(v / 27^m) with v < 2^20: (v * RECIP) >> SHIFT is exact
  localparam int SHIFT_27_1 = 25;
  localparam int SHIFT_27_2 = 30;
  localparam int SHIFT_27_3 = 35;
  localparam int RECIP_W    = 21;
  localparam logic [RECIP_W-1:0] RECIP_27_1 =
    RECIP_W'(((64'd1 << SHIFT_27_1) + 64'd27 - 64'd1) / 64'd27);
  localparam logic [RECIP_W-1:0] RECIP_27_2 =
    RECIP_W'(((64'd1 << SHIFT_27_2) + 64'd729 - 64'd1) / 64'd729);
  localparam logic [RECIP_W-1:0] RECIP_27_3 =
    RECIP_W'(((64'd1 << SHIFT_27_3) + 64'd19683 - 64'd1) / 64'd19683);
  localparam logic [OPND_W-1:0]  POW27_4 = 20'd531441;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Word operation codes
  typedef enum logic {
    OP_PAIR  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef logic [1:0] digit_t;

  // Running state handed from one carry stage to the next
  typedef struct packed {
    logic [FIELD_W-1:0] carry;
    logic [FIELD_W-1:0] top;
    logic [FIELD_W-1:0] below;
  } carry_state_t;

  // Split a base-27 chunk (0..26) into its three base-3 digits, high digit first.
  function automatic logic [5:0] chunk_digits(input logic [CHUNK_W-1:0] c);
    digit_t d2;
    digit_t d1;
    digit_t d0;
    logic [CHUNK_W-1:0] r;
    d2 = (c >= 5'd18) ? 2'd2 : ((c >= 5'd9) ? 2'd1 : 2'd0);
    r  = c - 5'(d2) * 5'd9;
    d1 = (r >= 5'd6) ? 2'd2 : ((r >= 5'd3) ? 2'd1 : 2'd0);
    d0 = 2'(r - 5'(d1) * 5'd3);
    return {d2, d1, d0};
  endfunction

  // Divide a small value by three: x * 171 / 512 is exact for x below 512.
  function automatic logic [FIELD_W-1:0] div3(input logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd171;
    return FIELD_W'(p[15:9]);
  endfunction

endpackage

// ----- hw/rtl/b3ptc_split.sv -----
// Two-stage base-3 digit extraction of one operand, masked to the active digit count.
module b3ptc_split #(
  parameter int MAX_DIGITS = 12
) (
  input  logic                               clk,
  input  logic [1:0]                         en_i,
  input  logic [3:0]                         k_i,
  input  logic [b3ptc_pkg::OPND_W-1:0]       opnd_i,
  output b3ptc_pkg::digit_t                  digit_o [MAX_DIGITS]
);

  localparam int PROD_W = b3ptc_pkg::OPND_W + b3ptc_pkg::RECIP_W;

  logic [PROD_W-1:0]                 prod1;
  logic [PROD_W-1:0]                 prod2;
  logic [PROD_W-1:0]                 prod3;
  logic [b3ptc_pkg::CHUNK_W-1:0]     quot_nxt [b3ptc_pkg::CHUNKS];
  logic [b3ptc_pkg::CHUNK_W-1:0]     quot_r   [b3ptc_pkg::CHUNKS];
  logic [b3ptc_pkg::CHUNK_W-1:0]     chunk    [b3ptc_pkg::CHUNKS];
  b3ptc_pkg::digit_t                 all_dig  [b3ptc_pkg::ALL_DIGITS];
  b3ptc_pkg::digit_t                 digit_nxt [MAX_DIGITS];
  b3ptc_pkg::digit_t                 digit_r   [MAX_DIGITS];

  // Quotients by powers of 27; only their low five bits are needed for the chunks.
  always_comb begin
    prod1 = PROD_W'(opnd_i) * PROD_W'(b3ptc_pkg::RECIP_27_1);
    prod2 = PROD_W'(opnd_i) * PROD_W'(b3ptc_pkg::RECIP_27_2);
    prod3 = PROD_W'(opnd_i) * PROD_W'(b3ptc_pkg::RECIP_27_3);
    quot_nxt[0] = opnd_i[b3ptc_pkg::CHUNK_W-1:0];
    quot_nxt[1] = prod1[b3ptc_pkg::SHIFT_27_1 +: b3ptc_pkg::CHUNK_W];
    quot_nxt[2] = prod2[b3ptc_pkg::SHIFT_27_2 +: b3ptc_pkg::CHUNK_W];
    quot_nxt[3] = prod3[b3ptc_pkg::SHIFT_27_3 +: b3ptc_pkg::CHUNK_W];
    quot_nxt[4] = b3ptc_pkg::CHUNK_W'(opnd_i >= b3ptc_pkg::POW27_4);
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      quot_r <= quot_nxt;
    end
  end

  // Chunk m is Q(m) - 27 * Q(m+1); the result is below 27, so five bits suffice.
  always_comb begin
    for (int m = 0; m < b3ptc_pkg::CHUNKS - 1; m++) begin
      chunk[m] = quot_r[m] - quot_r[m+1] * 5'd27;
    end
    chunk[b3ptc_pkg::CHUNKS-1] = quot_r[b3ptc_pkg::CHUNKS-1];
    for (int m = 0; m < b3ptc_pkg::CHUNKS; m++) begin
      {all_dig[3*m+2], all_dig[3*m+1], all_dig[3*m]} = b3ptc_pkg::chunk_digits(chunk[m]);
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digit_nxt[i] = (4'(i) < k_i) ? all_dig[i] : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit_o = digit_r;

endmodule

// ----- hw/rtl/b3ptc_conv.sv -----
// Registered digit convolution of the two operands.
module b3ptc_conv #(
  parameter int MAX_DIGITS = 12,
  parameter int CONV_LEN   = 28,
  parameter int CONV_W     = 6
) (
  input  logic              clk,
  input  logic              en_i,
  input  b3ptc_pkg::digit_t dig_a_i [MAX_DIGITS],
  input  b3ptc_pkg::digit_t dig_b_i [MAX_DIGITS],
  output logic [CONV_W-1:0] conv_o  [CONV_LEN]
);

  logic [CONV_W-1:0] conv_nxt [CONV_LEN];
  logic [CONV_W-1:0] conv_r   [CONV_LEN];

  // Each position sums the digit products whose indices add up to it.
  always_comb begin
    int j;
    for (int n = 0; n < CONV_LEN; n++) begin
      conv_nxt[n] = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        j = n - i;
        if (j >= 0 && j < MAX_DIGITS) begin
          conv_nxt[n] = conv_nxt[n] + CONV_W'(4'(dig_a_i[i]) * 4'(dig_b_i[j]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      conv_r <= conv_nxt;
    end
  end

  assign conv_o = conv_r;

endmodule

// ----- hw/rtl/b3ptc_carry.sv -----
// One carry stage: propagates base-3 carries over a few positions and tracks the top.
module b3ptc_carry #(
  parameter int CONV_LEN = 28,
  parameter int CONV_W   = 6,
  parameter int FIRST    = 0
) (
  input  logic                    clk,
  input  logic                    en_i,
  input  logic [4:0]              lim_i,
  input  logic [CONV_W-1:0]       conv_i  [CONV_LEN],
  input  b3ptc_pkg::carry_state_t state_i,
  output logic [CONV_W-1:0]       conv_o  [CONV_LEN],
  output b3ptc_pkg::carry_state_t state_o
);

  logic [CONV_W-1:0]       conv_r [CONV_LEN];
  b3ptc_pkg::carry_state_t state_nxt;
  b3ptc_pkg::carry_state_t state_r;

  // Carry into the next position; a nonzero carry within the limit becomes the new top.
  always_comb begin
    logic [7:0]                      sum;
    logic [b3ptc_pkg::FIELD_W-1:0]   nc;
    state_nxt = state_i;
    for (int t = 0; t < b3ptc_pkg::STEPS_PER_STAGE; t++) begin
      sum = 8'(conv_i[FIRST+t]) + 8'(state_nxt.carry);
      nc  = b3ptc_pkg::div3(sum);
      if (nc != '0 && 6'(FIRST + t + 1) <= {1'b0, lim_i}) begin
        state_nxt.top   = b3ptc_pkg::FIELD_W'(FIRST + t + 1);
        state_nxt.below = state_nxt.carry;
      end
      state_nxt.carry = nc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      conv_r  <= conv_i;
      state_r <= state_nxt;
    end
  end

  assign conv_o  = conv_r;
  assign state_o = state_r;

endmodule

// ----- hw/rtl/b3ptc_total.sv -----
// Result register and the two saturating running totals.
module b3ptc_total (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go_i,
  input  logic                                clr_i,
  input  b3ptc_pkg::carry_state_t             state_i,
  output logic                                pair_counted_o,
  output logic [b3ptc_pkg::FIELD_W-1:0]       top_o,
  output logic [b3ptc_pkg::FIELD_W-1:0]       below_o,
  output logic [b3ptc_pkg::TOTAL_W-1:0]       pairs_total_o,
  output logic [b3ptc_pkg::TOTAL_W-1:0]       carry_sum_total_o
);

  logic                              counted;
  logic [b3ptc_pkg::TOTAL_W:0]       csum;
  logic [b3ptc_pkg::TOTAL_W-1:0]     pair_acc_nxt;
  logic [b3ptc_pkg::TOTAL_W-1:0]     carry_acc_nxt;
  logic [b3ptc_pkg::TOTAL_W-1:0]     pair_acc_r;
  logic [b3ptc_pkg::TOTAL_W-1:0]     carry_acc_r;
  logic                              counted_r;
  logic [b3ptc_pkg::FIELD_W-1:0]     top_r;
  logic [b3ptc_pkg::FIELD_W-1:0]     below_r;

  assign counted = (state_i.top != '0);

  // Saturating updates of the totals; a clear word zeroes both.
  always_comb begin
    pair_acc_nxt  = pair_acc_r;
    carry_acc_nxt = carry_acc_r;
    csum = {1'b0, carry_acc_r} + (b3ptc_pkg::TOTAL_W + 1)'(state_i.below);
    if (clr_i) begin
      pair_acc_nxt  = '0;
      carry_acc_nxt = '0;
    end else if (counted) begin
      pair_acc_nxt  = (pair_acc_r == b3ptc_pkg::TOTAL_MAX) ? b3ptc_pkg::TOTAL_MAX
                                                             : pair_acc_r + 1'b1;
      carry_acc_nxt = csum[b3ptc_pkg::TOTAL_W] ? b3ptc_pkg::TOTAL_MAX
                                               : csum[b3ptc_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_acc_r  <= '0;
      carry_acc_r <= '0;
    end else if (go_i) begin
      pair_acc_r  <= pair_acc_nxt;
      carry_acc_r <= carry_acc_nxt;
    end
  end

  // Per-word result fields
  always_ff @(posedge clk) begin
    if (go_i) begin
      counted_r <= !clr_i && counted;
      top_r     <= clr_i ? '0 : state_i.top;
      below_r   <= (clr_i || !counted) ? '0 : state_i.below;
    end
  end

  assign pair_counted_o    = counted_r;
  assign top_o             = top_r;
  assign below_o           = below_r;
  assign pairs_total_o     = pair_acc_r;
  assign carry_sum_total_o = carry_acc_r;

  // A clear word leaves both totals at zero.
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    go_i && clr_i |=> pair_acc_r == '0 && carry_acc_r == '0)
    else $error("totals not cleared by clear word");

  // The pair total never falls except on a clear.
  a_pairs_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    go_i && !clr_i |=> pair_acc_r >= $past(pair_acc_r))
    else $error("pair total decreased");

  // A pair without a top leaves both totals untouched.
  a_uncounted_holds: assert property (@(posedge clk) disable iff (!rst_n)
    go_i && !clr_i && state_i.top == '0 |=>
      pair_acc_r == $past(pair_acc_r) && carry_acc_r == $past(carry_acc_r))
    else $error("totals changed by an uncounted pair");

endmodule

// ----- hw/rtl/base3_product_top_carry_stat.sv -----
// Top level of the base-3 product top-carry statistic: pipeline control and stages.
// Stages from input acceptance to out_valid: input register, quotient and digit stages,
// convolution stage, then carry stages of four positions each, then the result register.
// Throughput: one word per cycle while out_stall stays low; every stage advances independently and bubbles close up.
// Reset clears all stage valids, both running totals, and sets digit_count to 12.
module base3_product_top_carry_stat #(
  parameter int MAX_DIGITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [3:0]                         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic [b3ptc_pkg::OPND_W-1:0]       in_first_operand,
  input  logic [b3ptc_pkg::OPND_W-1:0]       in_second_operand,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_pair_counted,
  output logic [b3ptc_pkg::FIELD_W-1:0]      out_top_position,
  output logic [b3ptc_pkg::FIELD_W-1:0]      out_carry_below_top,
  output logic [b3ptc_pkg::TOTAL_W-1:0]      out_pairs_total,
  output logic [b3ptc_pkg::TOTAL_W-1:0]      out_carry_sum_total
);

  localparam int NSTEP    = 2 * MAX_DIGITS + 2;
  localparam int G        = b3ptc_pkg::STEPS_PER_STAGE;
  localparam int NCS      = (NSTEP + G - 1) / G;
  localparam int CONV_LEN = NCS * G;
  localparam int CONV_W   = $clog2(4 * MAX_DIGITS + 1);
  localparam int NSTG     = 4 + NCS;

  logic [3:0]                        digit_count_r;
  logic [3:0]                        k_eff;
  logic [4:0]                        lim;
  logic [NSTG:0]                     can;
  logic [NSTG-1:0]                   go;
  logic                              go_out;
  logic [NSTG-1:0]                   vld_nxt;
  logic [NSTG-1:0]                   vld_r;
  logic [NSTG-1:0]                   clr_r;
  logic                              out_valid_nxt;
  logic                              out_valid_r;
  logic [b3ptc_pkg::OPND_W-1:0]      opnd_a_r;
  logic [b3ptc_pkg::OPND_W-1:0]      opnd_b_r;
  b3ptc_pkg::digit_t                 dig_a [MAX_DIGITS];
  b3ptc_pkg::digit_t                 dig_b [MAX_DIGITS];
  logic [CONV_W-1:0]                 conv_w  [NCS+1][CONV_LEN];
  b3ptc_pkg::carry_state_t           state_w [NCS+1];

  // Digit count register and its clamped value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= 4'd12;
    end else if (cfg_wr_en) begin
      digit_count_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (digit_count_r < 4'd2) begin
      k_eff = 4'd2;
    end else if (digit_count_r > 4'(MAX_DIGITS)) begin
      k_eff = 4'(MAX_DIGITS);
    end else begin
      k_eff = digit_count_r;
    end
    lim = 5'({k_eff, 1'b0}) + 5'd2;
  end

  // Per-stage advance: a stage loads when it is empty or its word moves on.
  always_comb begin
    can[NSTG] = !out_valid_r || !out_stall;
    for (int s = NSTG - 1; s >= 0; s--) begin
      can[s] = !vld_r[s] || can[s+1];
    end
    go[0] = in_valid && can[0];
    for (int s = 1; s < NSTG; s++) begin
      go[s] = vld_r[s-1] && can[s];
    end
    go_out = vld_r[NSTG-1] && can[NSTG];
    for (int s = 0; s < NSTG; s++) begin
      vld_nxt[s] = go[s] || (vld_r[s] && !can[s+1]);
    end
    out_valid_nxt = go_out || (out_valid_r && out_stall);
  end

  assign in_stall  = !can[0];
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (go[0]) begin
        clr_r[0] <= (in_operation == b3ptc_pkg::OP_CLEAR);
      end
      for (int s = 1; s < NSTG; s++) begin
        if (go[s]) begin
          clr_r[s] <= clr_r[s-1];
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (go[0]) begin
      opnd_a_r <= in_first_operand;
      opnd_b_r <= in_second_operand;
    end
  end

  // Digit extraction of both operands
  b3ptc_split #(.MAX_DIGITS(MAX_DIGITS)) u_split_a (
    .clk     (clk),
    .en_i    ({go[2], go[1]}),
    .k_i     (k_eff),
    .opnd_i  (opnd_a_r),
    .digit_o (dig_a)
  );

  b3ptc_split #(.MAX_DIGITS(MAX_DIGITS)) u_split_b (
    .clk     (clk),
    .en_i    ({go[2], go[1]}),
    .k_i     (k_eff),
    .opnd_i  (opnd_b_r),
    .digit_o (dig_b)
  );

  // Convolution stage
  b3ptc_conv #(
    .MAX_DIGITS (MAX_DIGITS),
    .CONV_LEN   (CONV_LEN),
    .CONV_W     (CONV_W)
  ) u_conv (
    .clk     (clk),
    .en_i    (go[3]),
    .dig_a_i (dig_a),
    .dig_b_i (dig_b),
    .conv_o  (conv_w[0])
  );

  // Carry stages, four positions each; the carry into position zero is zero.
  assign state_w[0] = '0;

  for (genvar i = 0; i < NCS; i++) begin : g_carry
    b3ptc_carry #(
      .CONV_LEN (CONV_LEN),
      .CONV_W   (CONV_W),
      .FIRST    (i * G)
    ) u_carry (
      .clk     (clk),
      .en_i    (go[4+i]),
      .lim_i   (lim),
      .conv_i  (conv_w[i]),
      .state_i (state_w[i]),
      .conv_o  (conv_w[i+1]),
      .state_o (state_w[i+1])
    );
  end

  // Result register and running totals
  b3ptc_total u_total (
    .clk               (clk),
    .rst_n             (rst_n),
    .go_i              (go_out),
    .clr_i             (clr_r[NSTG-1]),
    .state_i           (state_w[NCS]),
    .pair_counted_o    (out_pair_counted),
    .top_o             (out_top_position),
    .below_o           (out_carry_below_top),
    .pairs_total_o     (out_pairs_total),
    .carry_sum_total_o (out_carry_sum_total)
  );

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result word valid after reset");

  // An uncounted result reports no top and no carry below it.
  a_uncounted_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pair_counted |->
      out_top_position == '0 && out_carry_below_top == '0)
    else $error("uncounted result with nonzero top fields");

  // The input is only stalled while the first stage holds a word.
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0])
    else $error("input stalled with an empty first stage");

endmodule

// ----- tb/b3ptc_stat_checker.sv -----
// Channel monitor, top-carry predictor and result comparison for the base-3 product block.
`timescale 1ns / 100ps

module b3ptc_stat_checker #(
  parameter int MAX_DIGITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [3:0]                    cfg_wr_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_operation,
  input  logic [b3ptc_pkg::OPND_W-1:0]  in_first_operand,
  input  logic [b3ptc_pkg::OPND_W-1:0]  in_second_operand,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_pair_counted,
  input  logic [b3ptc_pkg::FIELD_W-1:0] out_top_position,
  input  logic [b3ptc_pkg::FIELD_W-1:0] out_carry_below_top,
  input  logic [b3ptc_pkg::TOTAL_W-1:0] out_pairs_total,
  input  logic [b3ptc_pkg::TOTAL_W-1:0] out_carry_sum_total,
  output int                            pending_results,
  output int                            mismatches
);

  localparam logic [3:0] DIGITS_AT_RESET = 4'd12;
  localparam int         MIN_DIGITS      = 2;

  // One expected result word.
  typedef struct {
    logic                          counted;
    logic [b3ptc_pkg::FIELD_W-1:0] top;
    logic [b3ptc_pkg::FIELD_W-1:0] below;
    logic [b3ptc_pkg::TOTAL_W-1:0] pairs;
    logic [b3ptc_pkg::TOTAL_W-1:0] carry_sum;
  } carry_stat_t;

  logic [3:0]                    digit_count;
  logic [b3ptc_pkg::TOTAL_W-1:0] pairs_acc;
  logic [b3ptc_pkg::TOTAL_W-1:0] carry_sum_acc;
  carry_stat_t                   stats_q[$];
  carry_stat_t                   stat;
  carry_stat_t                   want;

  task automatic flag_mismatch(input string what,
                               input logic [b3ptc_pkg::TOTAL_W-1:0] got,
                               input logic [b3ptc_pkg::TOTAL_W-1:0] exp_val);
    $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  function automatic logic [b3ptc_pkg::TOTAL_W-1:0] add_saturating(
      input logic [b3ptc_pkg::TOTAL_W-1:0] acc,
      input logic [b3ptc_pkg::TOTAL_W-1:0] inc);
    logic [b3ptc_pkg::TOTAL_W:0] sum;
    sum = {1'b0, acc} + {1'b0, inc};
    return sum[b3ptc_pkg::TOTAL_W] ? b3ptc_pkg::TOTAL_MAX : sum[b3ptc_pkg::TOTAL_W-1:0];
  endfunction

  // Digit convolution, base-3 carry ripple and search for the highest nonzero carry.
  function automatic carry_stat_t top_carry_of(input logic [3:0] count,
                                               input logic [b3ptc_pkg::OPND_W-1:0] a,
                                               input logic [b3ptc_pkg::OPND_W-1:0] b);
    int          digits_a[MAX_DIGITS];
    int          digits_b[MAX_DIGITS];
    int          conv[2*MAX_DIGITS-1];
    int          carry[2*MAX_DIGITS+5];
    int          k;
    int          span;
    int          limit;
    int          top;
    int          pos;
    int unsigned va;
    int unsigned vb;
    carry_stat_t r;
    k = int'(count);
    if (k < MIN_DIGITS) k = MIN_DIGITS;
    if (k > MAX_DIGITS) k = MAX_DIGITS;
    span  = 2 * k - 1;
    limit = span + 4;
    va = 32'(a);
    vb = 32'(b);
    foreach (conv[i]) conv[i] = 0;
    foreach (carry[i]) carry[i] = 0;
    for (int i = 0; i < k; i++) begin
      digits_a[i] = va % 3;
      digits_b[i] = vb % 3;
      va = va / 3;
      vb = vb / 3;
    end
    for (int i = 0; i < k; i++)
      for (int j = 0; j < k; j++)
        conv[i+j] += digits_a[i] * digits_b[j];
    for (pos = 0; pos < span; pos++)
      carry[pos+1] = (conv[pos] + carry[pos]) / 3;
    // The top carry keeps shrinking until it dies out or the window ends.
    for (pos = span; pos < limit; pos++) begin
      if (carry[pos] == 0) break;
      carry[pos+1] = carry[pos] / 3;
    end
    top = 0;
    for (pos = limit - 1; pos >= 1; pos--) begin
      if (carry[pos] != 0) begin
        top = pos;
        break;
      end
    end
    r.counted   = (top != 0);
    r.top       = b3ptc_pkg::FIELD_W'(top);
    r.below     = r.counted ? b3ptc_pkg::FIELD_W'(carry[top-1]) : '0;
    r.pairs     = '0;
    r.carry_sum = '0;
    return r;
  endfunction

  // Track configuration, predict each accepted word and check each delivered result.
  always @(posedge clk) begin
    if (!rst_n) begin
      digit_count   = DIGITS_AT_RESET;
      pairs_acc     = '0;
      carry_sum_acc = '0;
      stats_q.delete();
    end else begin
      if (cfg_wr_en)
        digit_count = cfg_wr_data;

      if (in_valid && !in_stall) begin
        if (in_operation == b3ptc_pkg::OP_CLEAR) begin
          pairs_acc     = '0;
          carry_sum_acc = '0;
          stat = '{counted: 1'b0, top: '0, below: '0, pairs: '0, carry_sum: '0};
        end else begin
          stat = top_carry_of(digit_count, in_first_operand, in_second_operand);
          if (stat.counted) begin
            pairs_acc     = add_saturating(pairs_acc, b3ptc_pkg::TOTAL_W'(1));
            carry_sum_acc = add_saturating(carry_sum_acc, b3ptc_pkg::TOTAL_W'(stat.below));
          end
          stat.pairs     = pairs_acc;
          stat.carry_sum = carry_sum_acc;
        end
        stats_q.push_back(stat);
      end

      if (out_valid && !out_stall) begin
        if (stats_q.size() == 0) begin
          flag_mismatch("result word with none outstanding", out_pairs_total, '0);
        end else begin
          want = stats_q.pop_front();
          if (out_pair_counted !== want.counted)
            flag_mismatch("pair_counted", b3ptc_pkg::TOTAL_W'(out_pair_counted),
                          b3ptc_pkg::TOTAL_W'(want.counted));
          if (out_top_position !== want.top)
            flag_mismatch("top_position", b3ptc_pkg::TOTAL_W'(out_top_position),
                          b3ptc_pkg::TOTAL_W'(want.top));
          if (out_carry_below_top !== want.below)
            flag_mismatch("carry_below_top", b3ptc_pkg::TOTAL_W'(out_carry_below_top),
                          b3ptc_pkg::TOTAL_W'(want.below));
          if (out_pairs_total !== want.pairs)
            flag_mismatch("pairs_total", out_pairs_total, want.pairs);
          if (out_carry_sum_total !== want.carry_sum)
            flag_mismatch("carry_sum_total", out_carry_sum_total, want.carry_sum);
        end
      end
    end
    pending_results = stats_q.size();
  end

endmodule

// ----- tb/base3_product_top_carry_stat_tb.sv -----
// Stimulus, flow control and verdict for the base-3 product top-carry block.
`timescale 1ns / 100ps

module base3_product_top_carry_stat_tb;

  localparam int LONG_HOLD   = 150;
  localparam int WORDS_EACH  = 92;
  localparam int CLEAR_PCT   = 3;
  localparam int SETTLE_GAP  = 16;
  localparam logic [b3ptc_pkg::OPND_W-1:0] ALL_TWOS = 20'd531440;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [3:0]                    cfg_wr_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_operation = b3ptc_pkg::OP_PAIR;
  logic [b3ptc_pkg::OPND_W-1:0]  in_first_operand = '0;
  logic [b3ptc_pkg::OPND_W-1:0]  in_second_operand = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_pair_counted;
  logic [b3ptc_pkg::FIELD_W-1:0] out_top_position;
  logic [b3ptc_pkg::FIELD_W-1:0] out_carry_below_top;
  logic [b3ptc_pkg::TOTAL_W-1:0] out_pairs_total;
  logic [b3ptc_pkg::TOTAL_W-1:0] out_carry_sum_total;
  int                            pending_results;
  int                            mismatches;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #5 clk = ~clk;

  base3_product_top_carry_stat uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_first_operand    (in_first_operand),
    .in_second_operand   (in_second_operand),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pair_counted    (out_pair_counted),
    .out_top_position    (out_top_position),
    .out_carry_below_top (out_carry_below_top),
    .out_pairs_total     (out_pairs_total),
    .out_carry_sum_total (out_carry_sum_total)
  );

  b3ptc_stat_checker stat_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_first_operand    (in_first_operand),
    .in_second_operand   (in_second_operand),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pair_counted    (out_pair_counted),
    .out_top_position    (out_top_position),
    .out_carry_below_top (out_carry_below_top),
    .out_pairs_total     (out_pairs_total),
    .out_carry_sum_total (out_carry_sum_total),
    .pending_results     (pending_results),
    .mismatches          (mismatches)
  );

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one word, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_word(input b3ptc_pkg::op_t op,
                           input logic [b3ptc_pkg::OPND_W-1:0] a,
                           input logic [b3ptc_pkg::OPND_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_operation      = op;
    in_first_operand  = a;
    in_second_operand = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering words until every outstanding result has been delivered.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_digit_count(input logic [3:0] value);
    wait_for_results();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Operands: small values, all-twos patterns, full 20-bit noise and uniform values.
  function automatic logic [b3ptc_pkg::OPND_W-1:0] pick_operand();
    logic [b3ptc_pkg::OPND_W-1:0] v;
    int                           n;
    v = '0;
    case ($urandom_range(9))
      0: v = b3ptc_pkg::OPND_W'($urandom_range(8));
      1: v = ALL_TWOS;
      2: v = b3ptc_pkg::OPND_W'($urandom);
      3: begin
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++) v = v * 20'd3 + 20'd2;
      end
      default: v = b3ptc_pkg::OPND_W'($urandom_range(ALL_TWOS));
    endcase
    return v;
  endfunction

  // Hard stop in case the block hangs.
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [3:0] setting;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed words at the reset digit count of twelve.
    send_word(b3ptc_pkg::OP_CLEAR, '0, '0);
    send_word(b3ptc_pkg::OP_PAIR, 20'd0, 20'd0);
    send_word(b3ptc_pkg::OP_PAIR, 20'd1, 20'd1);
    send_word(b3ptc_pkg::OP_PAIR, 20'd2, 20'd2);           // top carry sits at position one
    send_word(b3ptc_pkg::OP_PAIR, ALL_TWOS, ALL_TWOS);
    send_word(b3ptc_pkg::OP_PAIR, 20'hFFFFF, 20'hFFFFF);   // digits beyond twelve are dropped
    send_word(b3ptc_pkg::OP_PAIR, ALL_TWOS, 20'd0);
    send_word(b3ptc_pkg::OP_PAIR, 20'd0, ALL_TWOS);
    send_word(b3ptc_pkg::OP_PAIR, 20'hFFFFF, 20'd1);
    send_word(b3ptc_pkg::OP_PAIR, 20'd524288, 20'd2);
    send_word(b3ptc_pkg::OP_PAIR, 20'd2, ALL_TWOS);
    send_word(b3ptc_pkg::OP_CLEAR, 20'hFFFFF, 20'hFFFFF);
    send_word(b3ptc_pkg::OP_PAIR, 20'd4, 20'd4);

    // A digit count below two acts as two.
    write_digit_count(4'd0);
    send_word(b3ptc_pkg::OP_PAIR, 20'd8, 20'd8);
    send_word(b3ptc_pkg::OP_PAIR, 20'd9, 20'd5);           // high digits of the operand ignored
    send_word(b3ptc_pkg::OP_PAIR, 20'hFFFFF, 20'hFFFFF);
    // A digit count above the maximum acts as the maximum.
    write_digit_count(4'd15);
    send_word(b3ptc_pkg::OP_PAIR, ALL_TWOS, ALL_TWOS);
    send_word(b3ptc_pkg::OP_PAIR, 20'd265720, 20'd265720);
    write_digit_count(4'd1);
    send_word(b3ptc_pkg::OP_PAIR, 20'd4, 20'd7);
    send_word(b3ptc_pkg::OP_CLEAR, '0, '0);

    // Random words over three flow-control phases, each through six digit counts.
    for (int phase = 0; phase < 3; phase++) begin
      wait_for_results();
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 6; sub++) begin
        setting = (phase * 6 + sub < 16) ? 4'(phase * 6 + sub) : 4'($urandom_range(15));
        write_digit_count(setting);
        // Hold the result side off while words keep coming, so the pipeline backs up.
        if (sub == 3)
          hold_ask++;
        for (int n = 0; n < WORDS_EACH; n++) begin
          if ($urandom_range(99) < CLEAR_PCT)
            send_word(b3ptc_pkg::OP_CLEAR, pick_operand(), pick_operand());
          else
            send_word(b3ptc_pkg::OP_PAIR, pick_operand(), pick_operand());
        end
      end
    end

    wait_for_results();
    repeat (SETTLE_GAP) @(negedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
